// ===== design/dssm_pkg.sv =====
// Shared constants and types for the dual stack shared memory block.
package dssm_pkg;

   localparam int DEPTH    = 16;
   localparam int ADDR_W   = $clog2(DEPTH);
   localparam int CNT_W    = $clog2(DEPTH + 1);
   localparam int DATA_W   = 32;
   localparam int MODE_W   = 3;
   localparam int STATUS_W = 2;
   localparam int COUNT_W  = 5;

   typedef logic [MODE_W-1:0]   mode_type;
   typedef logic [STATUS_W-1:0] status_type;

   localparam mode_type MODE_PUSH_ONE = 3'd0;
   localparam mode_type MODE_PUSH_TWO = 3'd1;
   localparam mode_type MODE_POP_ONE  = 3'd2;
   localparam mode_type MODE_POP_TWO  = 3'd3;
   localparam mode_type MODE_PEEK_ONE = 3'd4;
   localparam mode_type MODE_PEEK_TWO = 3'd5;

   localparam status_type STATUS_OK    = 2'd0;
   localparam status_type STATUS_OVER  = 2'd1;
   localparam status_type STATUS_UNDER = 2'd2;

   localparam logic [DATA_W-1:0] EMPTY_WORD = '1;

   typedef struct packed {
      logic capture;  // latch the request payload
      logic execute;  // decode, update counts, touch memory
      logic finish;   // load result from memory read data
   } dssm_cmd_type;

   typedef struct packed {
      logic read_issued;  // execute started a memory read
   } dssm_status_type;

endpackage

// ===== design/dssm_ctrl.sv =====
// Sequencing state machine for the dual stack shared memory block.
module dssm_ctrl (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_stall,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output dssm_pkg::dssm_cmd_type    cmd,
   input  dssm_pkg::dssm_status_type stat
);
   import dssm_pkg::*;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_EXEC,
      ST_FIN,
      ST_RESP
   } state_type;

   state_type state_ff;
   logic      req_stall_ff;
   logic      rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         req_stall_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         case (state_ff)
            ST_IDLE: begin
               if (req_valid) begin
                  state_ff     <= ST_EXEC;
                  req_stall_ff <= 1'b1;
               end
            end
            ST_EXEC: begin
               if (stat.read_issued) begin
                  state_ff <= ST_FIN;
               end else begin
                  state_ff     <= ST_RESP;
                  rsp_valid_ff <= 1'b1;
               end
            end
            ST_FIN: begin
               state_ff     <= ST_RESP;
               rsp_valid_ff <= 1'b1;
            end
            ST_RESP: begin
               if (!rsp_stall) begin
                  state_ff     <= ST_IDLE;
                  rsp_valid_ff <= 1'b0;
                  req_stall_ff <= 1'b0;
               end
            end
            default: begin
               state_ff     <= ST_IDLE;
               rsp_valid_ff <= 1'b0;
               req_stall_ff <= 1'b0;
            end
         endcase
      end
   end

   assign req_stall   = req_stall_ff;
   assign rsp_valid   = rsp_valid_ff;
   assign cmd.capture = (state_ff == ST_IDLE) && req_valid;
   assign cmd.execute = (state_ff == ST_EXEC);
   assign cmd.finish  = (state_ff == ST_FIN);

endmodule

// ===== design/dssm_datapath.sv =====
// Counters, shared word store and result registers of the two stacks.
module dssm_datapath (
   input  logic                            clock,
   input  logic                            reset,
   input  dssm_pkg::dssm_cmd_type           cmd,
   output dssm_pkg::dssm_status_type        stat,
   input  logic [dssm_pkg::MODE_W-1:0]      req_mode,
   input  logic signed [dssm_pkg::DATA_W-1:0] req_push_value,
   output logic signed [dssm_pkg::DATA_W-1:0] rsp_read_value,
   output logic [dssm_pkg::STATUS_W-1:0]    rsp_status,
   output logic [dssm_pkg::COUNT_W-1:0]     rsp_count_one,
   output logic [dssm_pkg::COUNT_W-1:0]     rsp_count_two
);
   import dssm_pkg::*;

   localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(DEPTH);
   localparam logic [CNT_W-1:0] ONE_C   = CNT_W'(1);

   mode_type          mode_ff;
   logic [DATA_W-1:0] value_ff;
   logic [CNT_W-1:0]  depth_one_ff, depth_one_in;
   logic [CNT_W-1:0]  depth_two_ff, depth_two_in;
   logic [DATA_W-1:0] mem [DEPTH];
   logic [DATA_W-1:0] mem_q_ff;

   logic [CNT_W:0]    used;
   logic              full;
   logic              wr_en;
   logic              read_go;
   logic [CNT_W-1:0]  wr_ptr, rd_ptr;
   logic [DATA_W-1:0] imm_value;
   status_type        imm_status;

   logic [DATA_W-1:0] rsp_value_ff;
   status_type        rsp_status_ff;
   logic [CNT_W-1:0]  rsp_one_ff, rsp_two_ff;
   logic [CNT_W+COUNT_W-1:0] one_ext, two_ext;

   assign used = {1'b0, depth_one_ff} + {1'b0, depth_two_ff};
   assign full = (used >= {1'b0, DEPTH_C});

   always_comb begin
      depth_one_in = depth_one_ff;
      depth_two_in = depth_two_ff;
      wr_en        = 1'b0;
      read_go      = 1'b0;
      wr_ptr       = depth_one_ff;
      rd_ptr       = depth_one_ff - ONE_C;
      imm_value    = '0;
      imm_status   = STATUS_OK;
      case (mode_ff)
         MODE_PUSH_ONE: begin
            if (full) begin
               imm_status = STATUS_OVER;
            end else begin
               wr_en        = 1'b1;
               wr_ptr       = depth_one_ff;
               depth_one_in = depth_one_ff + ONE_C;
            end
         end
         MODE_PUSH_TWO: begin
            if (full) begin
               imm_status = STATUS_OVER;
            end else begin
               wr_en        = 1'b1;
               wr_ptr       = DEPTH_C - depth_two_ff - ONE_C;
               depth_two_in = depth_two_ff + ONE_C;
            end
         end
         MODE_POP_ONE, MODE_PEEK_ONE: begin
            if (depth_one_ff == '0) begin
               imm_status = STATUS_UNDER;
               imm_value  = EMPTY_WORD;
            end else begin
               read_go = 1'b1;
               rd_ptr  = depth_one_ff - ONE_C;
               if (mode_ff == MODE_POP_ONE) depth_one_in = depth_one_ff - ONE_C;
            end
         end
         MODE_POP_TWO, MODE_PEEK_TWO: begin
            if (depth_two_ff == '0) begin
               imm_status = STATUS_UNDER;
               imm_value  = EMPTY_WORD;
            end else begin
               read_go = 1'b1;
               rd_ptr  = DEPTH_C - depth_two_ff;
               if (mode_ff == MODE_POP_TWO) depth_two_in = depth_two_ff - ONE_C;
            end
         end
         default: begin
            imm_status = STATUS_OK;
         end
      endcase
   end

   assign stat.read_issued = read_go;

   always_ff @(posedge clock) begin
      if (reset) begin
         depth_one_ff <= '0;
         depth_two_ff <= '0;
      end else if (cmd.execute) begin
         depth_one_ff <= depth_one_in;
         depth_two_ff <= depth_two_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         mode_ff  <= req_mode;
         value_ff <= req_push_value;
      end
   end

   // single write port, single registered read port
   always_ff @(posedge clock) begin
      if (cmd.execute && wr_en) mem[wr_ptr[ADDR_W-1:0]] <= value_ff;
      if (cmd.execute && read_go) mem_q_ff <= mem[rd_ptr[ADDR_W-1:0]];
   end

   always_ff @(posedge clock) begin
      if (cmd.execute && !read_go) begin
         rsp_value_ff  <= imm_value;
         rsp_status_ff <= imm_status;
         rsp_one_ff    <= depth_one_in;
         rsp_two_ff    <= depth_two_in;
      end else if (cmd.finish) begin
         // counts were already updated during execute
         rsp_value_ff  <= mem_q_ff;
         rsp_status_ff <= STATUS_OK;
         rsp_one_ff    <= depth_one_ff;
         rsp_two_ff    <= depth_two_ff;
      end
   end

   // counts are reported modulo the field width
   assign one_ext = {{COUNT_W{1'b0}}, rsp_one_ff};
   assign two_ext = {{COUNT_W{1'b0}}, rsp_two_ff};

   assign rsp_read_value = rsp_value_ff;
   assign rsp_status     = rsp_status_ff;
   assign rsp_count_one  = one_ext[COUNT_W-1:0];
   assign rsp_count_two  = two_ext[COUNT_W-1:0];

endmodule

// ===== design/dual_stack_shared_memory_core.sv =====
// Top level of the dual stack shared memory block.
// Two LIFO stacks share a store of DEPTH 32-bit words: stack one grows up from
// word 0, stack two down from word DEPTH-1. One request at a time is handled.
// A push, an unused mode or an error case steps through capture, execute and
// result transfer; a successful pop or peek adds a finish step between execute
// and result transfer, for the registered read port of the store. A stall on
// the result channel holds the result until it is taken. Words read from the
// store are only ever words pushed since reset, so no clearing pass exists.
module dual_stack_shared_memory_core (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic [dssm_pkg::MODE_W-1:0]         req_mode,
   input  logic signed [dssm_pkg::DATA_W-1:0]  req_push_value,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic signed [dssm_pkg::DATA_W-1:0]  rsp_read_value,
   output logic [dssm_pkg::STATUS_W-1:0]       rsp_status,
   output logic [dssm_pkg::COUNT_W-1:0]        rsp_count_one,
   output logic [dssm_pkg::COUNT_W-1:0]        rsp_count_two
);
   import dssm_pkg::*;

   dssm_cmd_type    cmd;
   dssm_status_type stat;

   dssm_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .cmd       (cmd),
      .stat      (stat)
   );

   dssm_datapath u_datapath (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .stat           (stat),
      .req_mode       (req_mode),
      .req_push_value (req_push_value),
      .rsp_read_value (rsp_read_value),
      .rsp_status     (rsp_status),
      .rsp_count_one  (rsp_count_one),
      .rsp_count_two  (rsp_count_two)
   );

endmodule

// ===== design/dssm_checker.sv =====
// Port-level checks for the dual stack shared memory block, bound to the top.
module dssm_checker (
   input logic                                clock,
   input logic                                reset,
   input logic                                req_valid,
   input logic                                req_stall,
   input logic                                rsp_valid,
   input logic                                rsp_stall,
   input logic signed [dssm_pkg::DATA_W-1:0]  rsp_read_value,
   input logic [dssm_pkg::STATUS_W-1:0]       rsp_status
);
   import dssm_pkg::*;

   // one transfer in flight: no request taken while a result waits
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> req_stall)
      else $error("request side open while a result is pending");

   // a result never appears in the cycle after a request transfer
   a_no_instant_result: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> !rsp_valid)
      else $error("result shown too early after request transfer");

   a_underflow_word: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status == STATUS_UNDER) |-> rsp_read_value == EMPTY_WORD)
      else $error("underflow result without all-ones word");

   a_overflow_word: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status == STATUS_OVER) |-> rsp_read_value == '0)
      else $error("overflow result with non-zero word");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> rsp_valid && $stable(rsp_read_value))
      else $error("stalled result changed");

endmodule

bind dual_stack_shared_memory_core dssm_checker u_dssm_checker (
   .clock          (clock),
   .reset          (reset),
   .req_valid      (req_valid),
   .req_stall      (req_stall),
   .rsp_valid      (rsp_valid),
   .rsp_stall      (rsp_stall),
   .rsp_read_value (rsp_read_value),
   .rsp_status     (rsp_status)
);

// ===== bench/tb_dual_stack_shared_memory_core.sv =====
// Self-checking testbench for the dual stack shared memory core.
module tb_dual_stack_shared_memory_core;
   timeunit 1ns;
   timeprecision 1ps;

   import dssm_pkg::*;

   // the two mode codes the block leaves unused
   localparam mode_type MODE_SPARE_LO = 3'd6;
   localparam mode_type MODE_SPARE_HI = 3'd7;

   localparam int RANDOM_ITEMS = 1800;
   localparam int MAX_PRINTS   = 40;

   typedef struct {
      mode_type                  mode;
      logic signed [DATA_W-1:0]  push_value;
   } stack_op_type;

   typedef struct {
      logic signed [DATA_W-1:0]  read_value;
      status_type                status;
      logic [COUNT_W-1:0]        count_one;
      logic [COUNT_W-1:0]        count_two;
   } stack_result_type;

   logic                        clock = 1'b0;
   logic                        reset = 1'b1;
   logic                        req_valid = 1'b0;
   logic                        req_stall;
   logic [MODE_W-1:0]           req_mode = '0;
   logic signed [DATA_W-1:0]    req_push_value = '0;
   logic                        rsp_valid;
   logic                        rsp_stall = 1'b0;
   logic signed [DATA_W-1:0]    rsp_read_value;
   logic [STATUS_W-1:0]         rsp_status;
   logic [COUNT_W-1:0]          rsp_count_one;
   logic [COUNT_W-1:0]          rsp_count_two;

   stack_op_type      pending_ops[$];
   stack_result_type  expected_results[$];

   // shadow of the block's state
   logic [DATA_W-1:0] stack_words[DEPTH];
   int                level_one = 0;
   int                level_two = 0;

   int  total_items   = 0;
   int  items_taken   = 0;
   int  results_seen  = 0;
   int  overflow_seen = 0;
   int  underflow_seen = 0;
   int  error_count   = 0;
   logic req_taken = 1'b0;
   int  req_gap   = 0;
   int  rsp_gap   = 0;

   dual_stack_shared_memory_core i_dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_mode       (req_mode),
      .req_push_value (req_push_value),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_read_value (rsp_read_value),
      .rsp_status     (rsp_status),
      .rsp_count_one  (rsp_count_one),
      .rsp_count_two  (rsp_count_two)
   );

   initial begin
      forever #10 clock = ~clock;
   end

   initial begin
      #5ms;
      $display("Verification failed");
      $finish;
   end

   task automatic report_mismatch(input string what);
      error_count++;
      if (error_count <= MAX_PRINTS) $display("%0t: ERROR %s", $realtime, what);
   endtask

   task automatic queue_op(input mode_type mode, input logic [DATA_W-1:0] value);
      stack_op_type op;
      op.mode = mode;
      op.push_value = value;
      pending_ops.push_back(op);
   endtask

   // idle stretches come and go; the tail of the run has none
   function automatic bit idling_allowed();
      return (items_taken + 150 < total_items) && ((items_taken / 120) % 4 != 3);
   endfunction

   function automatic stack_result_type apply_stack_op(mode_type mode,
                                                      logic [DATA_W-1:0] word);
      stack_result_type r;
      int used;
      used = level_one + level_two;
      r.read_value = '0;
      r.status = STATUS_OK;
      case (mode)
         MODE_PUSH_ONE: begin
            if (used >= DEPTH) r.status = STATUS_OVER;
            else begin
               stack_words[level_one] = word;
               level_one++;
            end
         end
         MODE_PUSH_TWO: begin
            if (used >= DEPTH) r.status = STATUS_OVER;
            else begin
               level_two++;
               stack_words[DEPTH - level_two] = word;
            end
         end
         MODE_POP_ONE, MODE_PEEK_ONE: begin
            if (level_one == 0) begin
               r.status = STATUS_UNDER;
               r.read_value = EMPTY_WORD;
            end else begin
               r.read_value = stack_words[level_one - 1];
               if (mode == MODE_POP_ONE) level_one--;
            end
         end
         MODE_POP_TWO, MODE_PEEK_TWO: begin
            if (level_two == 0) begin
               r.status = STATUS_UNDER;
               r.read_value = EMPTY_WORD;
            end else begin
               r.read_value = stack_words[DEPTH - level_two];
               if (mode == MODE_POP_TWO) level_two--;
            end
         end
         default: ;
      endcase
      r.count_one = COUNT_W'(level_one);
      r.count_two = COUNT_W'(level_two);
      return r;
   endfunction

   // request driver: new payload only after a transfer or while idle
   always @(negedge clock) begin
      stack_op_type op;
      if (reset) begin
         req_valid <= 1'b0;
         req_gap <= 0;
      end else if (!(req_valid && !req_taken)) begin
         if (req_gap > 0) begin
            req_valid <= 1'b0;
            req_gap <= req_gap - 1;
         end else if (pending_ops.size() == 0) begin
            req_valid <= 1'b0;
         end else if (idling_allowed() && $urandom_range(0, 7) == 0) begin
            req_valid <= 1'b0;
            req_gap <= $urandom_range(0, 2);
         end else begin
            op = pending_ops.pop_front();
            req_valid <= 1'b1;
            req_mode <= op.mode;
            req_push_value <= op.push_value;
         end
      end
   end

   // result side back-pressure
   always @(negedge clock) begin
      if (rsp_gap > 0) begin
         rsp_stall <= 1'b1;
         rsp_gap <= rsp_gap - 1;
      end else if (!reset && idling_allowed() && $urandom_range(0, 7) == 0) begin
         rsp_stall <= 1'b1;
         rsp_gap <= $urandom_range(0, 2);
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   // monitor: predicts on each request transfer, checks each result transfer
   always @(posedge clock) begin
      stack_result_type want;
      if (reset) begin
         req_taken <= 1'b0;
      end else begin
         req_taken <= req_valid && !req_stall;
         if (rsp_valid && !rsp_stall) begin
            results_seen++;
            if (expected_results.size() == 0) begin
               report_mismatch("result transfer with nothing outstanding");
            end else begin
               want = expected_results.pop_front();
               if (want.status == STATUS_OVER) overflow_seen++;
               if (want.status == STATUS_UNDER) underflow_seen++;
               if (rsp_read_value !== want.read_value)
                  report_mismatch($sformatf("read_value %h, expected %h",
                                            rsp_read_value, want.read_value));
               if (rsp_status !== want.status)
                  report_mismatch($sformatf("status %0d, expected %0d",
                                            rsp_status, want.status));
               if (rsp_count_one !== want.count_one)
                  report_mismatch($sformatf("count_one %0d, expected %0d",
                                            rsp_count_one, want.count_one));
               if (rsp_count_two !== want.count_two)
                  report_mismatch($sformatf("count_two %0d, expected %0d",
                                            rsp_count_two, want.count_two));
            end
         end
         if (req_valid && !req_stall) begin
            expected_results.push_back(apply_stack_op(req_mode, req_push_value));
            items_taken++;
         end
      end
   end

   initial begin
      int made;
      int n;
      int kind;
      int pick;
      mode_type m;

      // empty stacks, unused modes and extreme words
      queue_op(MODE_POP_ONE, 32'h0);
      queue_op(MODE_POP_TWO, 32'h0);
      queue_op(MODE_PEEK_ONE, 32'h0);
      queue_op(MODE_PEEK_TWO, 32'h0);
      queue_op(MODE_SPARE_LO, 32'hFFFF_FFFF);
      queue_op(MODE_SPARE_HI, 32'h0);
      queue_op(MODE_PUSH_ONE, 32'h7FFF_FFFF);
      queue_op(MODE_PUSH_TWO, 32'h8000_0000);
      // fill the store completely, then push into it twice more
      for (int i = 0; i < DEPTH - 2; i++)
         queue_op(i[0] ? MODE_PUSH_TWO : MODE_PUSH_ONE, $urandom);
      queue_op(MODE_PUSH_ONE, 32'hFFFF_FFFF);
      queue_op(MODE_PUSH_TWO, 32'h0);
      queue_op(MODE_PEEK_ONE, 32'h0);
      queue_op(MODE_PEEK_TWO, 32'h0);

      // random part in episodes; the first one pops and peeks from the full store
      made = 0;
      kind = 4;
      while (made < RANDOM_ITEMS) begin
         case (kind)
            0, 1, 2: begin
               n = DEPTH - 2 + $urandom_range(0, 8);
               for (int i = 0; i < n; i++) begin
                  if ($urandom_range(0, 5) == 0)
                     m = $urandom_range(0, 1) ? MODE_PEEK_TWO : MODE_PEEK_ONE;
                  else
                     m = $urandom_range(0, 1) ? MODE_PUSH_TWO : MODE_PUSH_ONE;
                  queue_op(m, $urandom);
               end
            end
            3, 4, 5: begin
               n = 20 + $urandom_range(0, 16);
               for (int i = 0; i < n; i++) begin
                  pick = $urandom_range(0, 3);
                  if (pick == 0)
                     m = $urandom_range(0, 1) ? MODE_PEEK_TWO : MODE_PEEK_ONE;
                  else
                     m = $urandom_range(0, 1) ? MODE_POP_TWO : MODE_POP_ONE;
                  queue_op(m, $urandom);
               end
            end
            6, 7, 8: begin
               n = 10 + $urandom_range(0, 30);
               for (int i = 0; i < n; i++) begin
                  if ($urandom_range(0, 19) == 0)
                     m = $urandom_range(0, 1) ? MODE_SPARE_HI : MODE_SPARE_LO;
                  else
                     m = mode_type'($urandom_range(0, 5));
                  queue_op(m, $urandom);
               end
            end
            default: begin
               n = $urandom_range(3, 10);
               for (int i = 0; i < n; i++)
                  queue_op(mode_type'($urandom_range(0, 7)), $urandom);
            end
         endcase
         made += n;
         kind = $urandom_range(0, 9);
      end
      total_items = pending_ops.size();

      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      while (items_taken < total_items) @(posedge clock);
      while (expected_results.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);
      if (expected_results.size() != 0)
         report_mismatch($sformatf("%0d results never arrived", expected_results.size()));

      $display("Checked %0d results for %0d requests over both stacks and all modes;",
               results_seen, total_items);
      $display("%0d overflow and %0d underflow responses among them, %0d mismatches.",
               overflow_seen, underflow_seen, error_count);
      if (error_count == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule
